FILE: sv/dlh_pkg.sv
// Shared types, constants and helpers for the dynamic line hull block.
// Used by every module of the block but dlh_ram; depends on nothing.
`default_nettype none

package dlh_pkg;

   localparam int MaxLines = 64;
   localparam int CoefBits = 32;

   localparam int CntW  = $clog2(MaxLines + 1);
   localparam int AddrW = $clog2(MaxLines);
   localparam int InW   = 32;
   localparam int CoefW = 33;
   localparam int DivW  = 34;
   localparam int BpW   = DivW + 1;
   localparam int ValW  = 64;
   localparam int StepW = $clog2(DivW + 1);

   localparam logic signed [BpW-1:0] BpHi = {1'b0, {(BpW-1){1'b1}}};
   localparam logic signed [BpW-1:0] BpLo = {1'b1, {(BpW-1){1'b0}}};

   localparam logic ReqInsert = 1'b0;
   localparam logic ReqQuery  = 1'b1;

   localparam logic [1:0] StOk    = 2'd0;
   localparam logic [1:0] StEmpty = 2'd1;
   localparam logic [1:0] StFull  = 2'd2;

   typedef struct packed {
      logic signed [CoefW-1:0] m;
      logic signed [CoefW-1:0] c;
      logic signed [BpW-1:0]   bp;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_FULL, OP_EMPTY, OP_OK, OP_RD_K, OP_K_INC, OP_Q_MUL,
      OP_Q_ADD, OP_SET_POS, OP_RD_KM1, OP_WR_K_DEC, OP_INSERT, OP_RD_WI, OP_LD0,
      OP_LD1, OP_DIV_WAIT, OP_SB_WR, OP_RM_UP, OP_WI_DEC, OP_RD_WIM1, OP_C4_LD0,
      OP_RM_AT, OP_RM_END, OP_RM_END_DEC, OP_RD_K1, OP_WR_K_INC, OP_PUBLISH
   } dlh_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_Q_RD, S_Q_CHK, S_Q_ADD, S_P_RD, S_P_CHK, S_SH_RD,
      S_SH_WR, S_INS_WR, S_SB_RD0, S_SB_LD0, S_SB_LD1, S_SB_DIV, S_SB_WR,
      S_SB_RET, S_C4, S_C4_LD0, S_C4_LD1, S_RM_RD, S_RM_WR, S_DONE
   } dlh_state_type;

   typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_D} dlh_phase_type;

   typedef struct packed {
      logic is_query;
      logic cnt_zero;
      logic cnt_full;
      logic k_eq_cnt;
      logic k1_ge_cnt;
      logic k_eq_pos;
      logic p_gt;
      logic q_more;
      logic wi_zero;
      logic wi1_ge_cnt;
      logic slope_eq;
      logic div_done;
      logic hid;
      logic c4_rm;
      logic rsp_free;
   } dlh_stat_type;

   function automatic logic signed [CoefW-1:0] coef_sext(input logic [InW-1:0] v);
      return CoefW'($signed(v[CoefBits-1:0]));
   endfunction

endpackage

`default_nettype wire

FILE: sv/dlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module dlh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/dlh_div.sv
// Serial restoring divider, one quotient bit per cycle, floor rounding.
// Depends on dlh_pkg.
`default_nettype none

module dlh_div import dlh_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [DivW-1:0] dividend,
   input  wire logic signed [DivW-1:0] divisor,
   output logic                        done,
   output logic signed [BpW-1:0]       quotient
);

   logic [StepW-1:0] step_ff, step_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [DivW-1:0]  rem_ff, rem_in;
   logic [DivW-1:0]  quo_ff, quo_in;
   logic [DivW-1:0]  bmag_ff, bmag_in;
   logic [DivW:0]    shifted;
   logic [DivW:0]    diff;
   logic [BpW-1:0]   qx;

   always_comb begin
      shifted = {rem_ff, quo_ff[DivW-1]};
      diff    = shifted - {1'b0, bmag_ff};
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      bmag_in = bmag_ff;
      done_in = done_ff;
      if (start) begin
         step_in = StepW'(DivW);
         neg_in  = dividend[DivW-1] ^ divisor[DivW-1];
         rem_in  = '0;
         quo_in  = dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
         bmag_in = divisor[DivW-1] ? DivW'(-divisor) : DivW'(divisor);
         done_in = 1'b0;
      end else if (step_ff != '0) begin
         rem_in  = diff[DivW] ? shifted[DivW-1:0] : diff[DivW-1:0];
         quo_in  = {quo_ff[DivW-2:0], ~diff[DivW]};
         step_in = step_ff - StepW'(1);
         done_in = (step_ff == StepW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bmag_ff <= bmag_in;
   end

   // a negative quotient with a remainder rounds down: -q - 1 is ~q
   always_comb begin
      qx = {1'b0, quo_ff};
      if (!neg_ff) begin
         quotient = qx;
      end else if (rem_ff == '0) begin
         quotient = -qx;
      end else begin
         quotient = ~qx;
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

FILE: sv/dlh_datapath.sv
// Datapath: line table RAM, work registers, divider, multiplier, CSR, result register.
// Depends on dlh_pkg, dlh_ram and dlh_div.
`default_nettype none

module dlh_datapath import dlh_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dlh_op_type              op,
   output dlh_stat_type                 stat,
   input  wire logic                    req_type,
   input  wire logic [InW-1:0]          req_line_slope,
   input  wire logic [InW-1:0]          req_line_intercept,
   input  wire logic [InW-1:0]          req_query_x,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [ValW-1:0]       rsp_envelope_value,
   output logic [CntW-1:0]              rsp_line_count,
   output logic [1:0]                   rsp_status,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [2:0]              paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata
);

   logic                    mode_ff, mode_in;
   logic                    type_ff, type_in;
   logic signed [CoefW-1:0] m_ff, m_in;
   logic signed [CoefW-1:0] c_ff, c_in;
   logic signed [InW-1:0]   x_ff, x_in;
   logic [CntW-1:0]         k_ff, k_in;
   logic [CntW-1:0]         pos_ff, pos_in;
   logic [CntW-1:0]         wi_ff, wi_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   entry_type               e0_ff, e0_in;
   entry_type               e1_ff, e1_in;
   logic signed [BpW-1:0]   nb_ff, nb_in;
   logic                    hasj_ff, hasj_in;
   logic                    hid_ff, hid_in;
   logic signed [ValW-1:0]  prod_ff, prod_in;
   logic signed [CoefW-1:0] cq_ff, cq_in;
   logic signed [ValW-1:0]  res_value_ff, res_value_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ValW-1:0]  rsp_value_ff, rsp_value_in;
   logic [CntW-1:0]         rsp_count_ff, rsp_count_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   logic                    wr_en;
   logic [AddrW-1:0]        wr_addr;
   entry_type               wr_data;
   logic [AddrW-1:0]        rd_addr;
   logic [EntryW-1:0]       rd_raw;
   entry_type               rd;
   logic [CntW-1:0]         k_inc, k_dec, wi_inc, wi_dec;
   logic signed [BpW-1:0]   x_ext;
   logic signed [2*CoefW-2:0] prod_full;
   logic signed [ValW-1:0]  sum;
   logic                    div_start;
   logic                    div_done;
   logic signed [DivW-1:0]  div_a, div_b;
   logic signed [BpW-1:0]   div_q;
   logic                    csr_wr;
   logic signed [CoefW-1:0] in_m, in_c;

   dlh_ram #(.Width(EntryW), .Depth(MaxLines)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   dlh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rd        = entry_type'(rd_raw);
   assign k_inc     = k_ff + CntW'(1);
   assign k_dec     = k_ff - CntW'(1);
   assign wi_inc    = wi_ff + CntW'(1);
   assign wi_dec    = wi_ff - CntW'(1);
   assign x_ext     = BpW'(x_ff);
   assign prod_full = rd.m * x_ff;
   assign sum       = prod_ff + ValW'(cq_ff);
   assign div_a     = DivW'(rd.c) - DivW'(e0_ff.c);
   assign div_b     = DivW'(e0_ff.m) - DivW'(rd.m);
   assign csr_wr    = psel && penable && pwrite && !paddr[2];
   assign prdata    = paddr[2] ? 32'd0 : {31'd0, mode_ff};
   assign in_m      = coef_sext(req_line_slope);
   assign in_c      = coef_sext(req_line_intercept);

   always_comb begin
      stat.is_query   = (type_ff == ReqQuery);
      stat.cnt_zero   = (cnt_ff == '0);
      stat.cnt_full   = (cnt_ff == CntW'(MaxLines));
      stat.k_eq_cnt   = (k_ff == cnt_ff);
      stat.k1_ge_cnt  = (k_inc >= cnt_ff);
      stat.k_eq_pos   = (k_ff == pos_ff);
      stat.p_gt       = (rd.m > m_ff);
      stat.q_more     = (k_inc < cnt_ff) && (rd.bp < x_ext);
      stat.wi_zero    = (wi_ff == '0);
      stat.wi1_ge_cnt = (wi_inc >= cnt_ff);
      stat.slope_eq   = (e0_ff.m == rd.m);
      stat.div_done   = div_done;
      stat.hid        = hid_ff;
      stat.c4_rm      = (e1_ff.bp >= rd.bp);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      mode_in       = csr_wr ? pwdata[0] : mode_ff;
      type_in       = type_ff;
      m_in          = m_ff;
      c_in          = c_ff;
      x_in          = x_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      wi_in         = wi_ff;
      cnt_in        = cnt_ff;
      e0_in         = e0_ff;
      e1_in         = e1_ff;
      nb_in         = nb_ff;
      hasj_in       = hasj_ff;
      hid_in        = hid_ff;
      prod_in       = prod_ff;
      cq_in         = cq_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = k_ff[AddrW-1:0];
      wr_data       = rd;
      rd_addr       = k_ff[AddrW-1:0];
      div_start     = 1'b0;
      case (op)
         OP_ACCEPT: begin
            type_in = req_type;
            m_in    = mode_ff ? -in_m : in_m;
            c_in    = mode_ff ? -in_c : in_c;
            x_in    = $signed(req_query_x);
            k_in    = '0;
         end
         OP_FULL: begin
            res_value_in  = '0;
            res_status_in = StFull;
         end
         OP_EMPTY: begin
            res_value_in  = '0;
            res_status_in = StEmpty;
         end
         OP_OK: begin
            res_value_in  = '0;
            res_status_in = StOk;
         end
         OP_RD_K: rd_addr = k_ff[AddrW-1:0];
         OP_K_INC: k_in = k_inc;
         OP_Q_MUL: begin
            prod_in = prod_full[ValW-1:0];
            cq_in   = rd.c;
         end
         OP_Q_ADD: begin
            res_value_in  = mode_ff ? -sum : sum;
            res_status_in = StOk;
         end
         OP_SET_POS: begin
            pos_in = k_ff;
            k_in   = cnt_ff;
         end
         OP_RD_KM1: rd_addr = k_dec[AddrW-1:0];
         OP_WR_K_DEC: begin
            wr_en = 1'b1;
            k_in  = k_dec;
         end
         OP_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AddrW-1:0];
            wr_data = '{m: m_ff, c: c_ff, bp: '0};
            cnt_in  = cnt_ff + CntW'(1);
            wi_in   = pos_ff;
         end
         OP_RD_WI: rd_addr = wi_ff[AddrW-1:0];
         OP_LD0: begin
            e0_in   = rd;
            rd_addr = wi_inc[AddrW-1:0];
            nb_in   = BpHi;
            hasj_in = !stat.wi1_ge_cnt;
         end
         OP_LD1: begin
            e1_in = rd;
            if (stat.slope_eq) begin
               nb_in = (e0_ff.c > rd.c) ? BpHi : BpLo;
            end else begin
               div_start = 1'b1;
            end
         end
         OP_DIV_WAIT: begin
            if (div_done) begin
               nb_in = div_q;
            end
         end
         OP_SB_WR: begin
            wr_en    = 1'b1;
            wr_addr  = wi_ff[AddrW-1:0];
            wr_data  = '{m: e0_ff.m, c: e0_ff.c, bp: nb_ff};
            e0_in.bp = nb_ff;
            hid_in   = hasj_ff && (nb_ff >= e1_ff.bp);
         end
         OP_RM_UP: k_in = wi_inc;
         OP_WI_DEC: wi_in = wi_dec;
         OP_RD_WIM1: rd_addr = wi_dec[AddrW-1:0];
         OP_C4_LD0: begin
            e1_in   = rd;
            rd_addr = wi_ff[AddrW-1:0];
         end
         OP_RM_AT: k_in = wi_ff;
         OP_RM_END: cnt_in = cnt_ff - CntW'(1);
         OP_RM_END_DEC: begin
            cnt_in = cnt_ff - CntW'(1);
            wi_in  = wi_dec;
         end
         OP_RD_K1: rd_addr = k_inc[AddrW-1:0];
         OP_WR_K_INC: begin
            wr_en = 1'b1;
            k_in  = k_inc;
         end
         OP_PUBLISH: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = res_value_ff;
            rsp_count_in  = cnt_ff;
            rsp_status_in = res_status_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      m_ff          <= m_in;
      c_ff          <= c_in;
      x_ff          <= x_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      wi_ff         <= wi_in;
      e0_ff         <= e0_in;
      e1_ff         <= e1_in;
      nb_ff         <= nb_in;
      hasj_ff       <= hasj_in;
      hid_ff        <= hid_in;
      prod_ff       <= prod_in;
      cq_ff         <= cq_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_envelope_value = rsp_value_ff;
   assign rsp_line_count     = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

FILE: sv/dlh_ctrl.sv
// Sequencer for insert and query words; issues one datapath command per cycle.
// Depends on dlh_pkg.
`default_nettype none

module dlh_ctrl import dlh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire dlh_stat_type stat,
   output dlh_op_type        op
);

   dlh_state_type state_ff, state_in;
   dlh_phase_type phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (stat.is_query) begin
               state_in = stat.cnt_zero ? S_DONE : S_Q_RD;
            end else begin
               state_in = stat.cnt_full ? S_DONE : S_P_RD;
            end
         end
         S_Q_RD:   state_in = S_Q_CHK;
         S_Q_CHK:  state_in = stat.q_more ? S_Q_RD : S_Q_ADD;
         S_Q_ADD:  state_in = S_DONE;
         S_P_RD:   state_in = stat.k_eq_cnt ? S_SH_RD : S_P_CHK;
         S_P_CHK:  state_in = stat.p_gt ? S_SH_RD : S_P_RD;
         S_SH_RD:  state_in = stat.k_eq_pos ? S_INS_WR : S_SH_WR;
         S_SH_WR:  state_in = S_SH_RD;
         S_INS_WR: begin
            state_in = S_SB_RD0;
            phase_in = PH_A;
         end
         S_SB_RD0: state_in = S_SB_LD0;
         S_SB_LD0: state_in = stat.wi1_ge_cnt ? S_SB_WR : S_SB_LD1;
         S_SB_LD1: state_in = stat.slope_eq ? S_SB_WR : S_SB_DIV;
         S_SB_DIV: if (stat.div_done) state_in = S_SB_WR;
         S_SB_WR:  state_in = S_SB_RET;
         S_SB_RET: begin
            if ((phase_ff == PH_A || phase_ff == PH_B) && stat.hid) begin
               state_in = S_RM_RD;
            end else if (phase_ff == PH_A && !stat.wi_zero) begin
               state_in = S_SB_RD0;
               phase_in = PH_B;
            end else begin
               state_in = S_C4;
            end
         end
         S_C4:     state_in = stat.wi_zero ? S_DONE : S_C4_LD0;
         S_C4_LD0: state_in = S_C4_LD1;
         S_C4_LD1: begin
            if (stat.c4_rm) begin
               state_in = S_RM_RD;
               phase_in = PH_D;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RM_RD: begin
            if (stat.k1_ge_cnt) begin
               state_in = S_SB_RD0;
               if (phase_ff == PH_B) phase_in = PH_C;
            end else begin
               state_in = S_RM_WR;
            end
         end
         S_RM_WR:  state_in = S_RM_RD;
         S_DONE:   if (stat.rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      case (state_ff)
         S_IDLE:     if (req_valid) op = OP_ACCEPT;
         S_DISPATCH: begin
            if (stat.is_query && stat.cnt_zero) begin
               op = OP_EMPTY;
            end else if (!stat.is_query && stat.cnt_full) begin
               op = OP_FULL;
            end
         end
         S_Q_RD:   op = OP_RD_K;
         S_Q_CHK:  op = stat.q_more ? OP_K_INC : OP_Q_MUL;
         S_Q_ADD:  op = OP_Q_ADD;
         S_P_RD:   op = stat.k_eq_cnt ? OP_SET_POS : OP_RD_K;
         S_P_CHK:  op = stat.p_gt ? OP_SET_POS : OP_K_INC;
         S_SH_RD:  if (!stat.k_eq_pos) op = OP_RD_KM1;
         S_SH_WR:  op = OP_WR_K_DEC;
         S_INS_WR: op = OP_INSERT;
         S_SB_RD0: op = OP_RD_WI;
         S_SB_LD0: op = OP_LD0;
         S_SB_LD1: op = OP_LD1;
         S_SB_DIV: op = OP_DIV_WAIT;
         S_SB_WR:  op = OP_SB_WR;
         S_SB_RET: begin
            if ((phase_ff == PH_A || phase_ff == PH_B) && stat.hid) begin
               op = OP_RM_UP;
            end else if (phase_ff == PH_A && !stat.wi_zero) begin
               op = OP_WI_DEC;
            end
         end
         S_C4:     op = stat.wi_zero ? OP_OK : OP_RD_WIM1;
         S_C4_LD0: op = OP_C4_LD0;
         S_C4_LD1: op = stat.c4_rm ? OP_RM_AT : OP_OK;
         S_RM_RD: begin
            if (!stat.k1_ge_cnt) begin
               op = OP_RD_K1;
            end else if (phase_ff == PH_D) begin
               op = OP_RM_END_DEC;
            end else begin
               op = OP_RM_END;
            end
         end
         S_RM_WR:  op = OP_WR_K_INC;
         S_DONE:   if (stat.rsp_free) op = OP_PUBLISH;
         default:  op = OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/dynamic_line_hull.sv
// Line container for the convex hull trick: top level, APB-style register port.
// Depends on dlh_pkg, dlh_ctrl and dlh_datapath.
//
// Usage:
//   req channel (valid/ready): req_type 0 inserts the line
//   req_line_slope*x + req_line_intercept, req_type 1 queries the envelope at
//   req_query_x. Every word gives exactly one rsp word: the envelope value
//   (queries only), the line count after the request, and a status.
//   hull_mode at byte address 0 picks max (0) or min (1) envelope.
// Operation:
//   One word in flight. A query reads the held lines in turn until it finds
//   the one whose span holds req_query_x. An insert passes lines in the slope
//   search, shifts lines in the table, recomputes breakpoints with the serial
//   divider and moves entries on each removal. The table RAM (one read port
//   and one write port, registered read) and the divider set the run time.
// Reset: the table is emptied and the minimum envelope is selected.
// Stall: a finished rsp word holds in its output register; the next req word
//   is taken meanwhile, and its result waits until that register frees up.
`default_nettype none

module dynamic_line_hull import dlh_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [InW-1:0]       req_line_slope,
   input  wire logic [InW-1:0]       req_line_intercept,
   input  wire logic [InW-1:0]       req_query_x,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [ValW-1:0]    rsp_envelope_value,
   output logic [CntW-1:0]           rsp_line_count,
   output logic [1:0]                rsp_status,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   dlh_op_type   op;
   dlh_stat_type stat;

   assign pready = 1'b1;

   dlh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   dlh_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .stat               (stat),
      .req_type           (req_type),
      .req_line_slope     (req_line_slope),
      .req_line_intercept (req_line_intercept),
      .req_query_x        (req_query_x),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_envelope_value (rsp_envelope_value),
      .rsp_line_count     (rsp_line_count),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata)
   );

endmodule

`default_nettype wire

FILE: tb/sv/dynamic_line_hull_tb.sv
// Self-checking bench for dynamic_line_hull: directed and random insert/query words against a
// behavioral line table. Depends on dlh_pkg and the dynamic_line_hull RTL.
`default_nettype none

module dynamic_line_hull_tb;
   import dlh_pkg::*;

   localparam int Depth = 64;
   localparam logic [2:0] AddrHullMode = 3'd0;
   localparam logic signed [63:0] BreakHi = 64'sd17179869183;
   localparam logic signed [63:0] BreakLo = -64'sd17179869184;

   typedef struct {
      logic        kind;
      logic [31:0] slope;
      logic [31:0] icpt;
      logic [31:0] x;
   } req_word_type;

   typedef struct {
      logic signed [63:0] value;
      logic [CntW-1:0]    count;
      logic [1:0]         status;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [31:0] req_line_slope = '0, req_line_intercept = '0, req_query_x = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [63:0] rsp_envelope_value;
   logic [CntW-1:0] rsp_line_count;
   logic [1:0] rsp_status;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   dynamic_line_hull i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_line_slope(req_line_slope), .req_line_intercept(req_line_intercept),
      .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_envelope_value(rsp_envelope_value), .rsp_line_count(rsp_line_count),
      .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // hull model state
   logic signed [63:0] tbl_m [Depth+1];
   logic signed [63:0] tbl_c [Depth+1];
   logic signed [63:0] tbl_bp [Depth+1];
   int unsigned tbl_cnt;
   logic model_min;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int errors = 0;
   bit quiet_in = 1'b0, quiet_out = 1'b0;

   // latch the accept so the driver sees it at the following falling edge
   logic req_ready_seen = 1'b0;

   initial forever #10 clock = ~clock;

   function automatic logic signed [63:0] floor_quot(logic signed [63:0] a,
                                                     logic signed [63:0] b);
      logic signed [63:0] q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic bit refresh_break(int unsigned i, int unsigned j);
      if (j >= tbl_cnt) begin
         tbl_bp[i] = BreakHi;
         return 1'b0;
      end
      if (tbl_m[i] == tbl_m[j])
         tbl_bp[i] = (tbl_c[i] > tbl_c[j]) ? BreakHi : BreakLo;
      else
         tbl_bp[i] = floor_quot(tbl_c[j] - tbl_c[i], tbl_m[i] - tbl_m[j]);
      return tbl_bp[i] >= tbl_bp[j];
   endfunction

   function automatic void drop_line(int unsigned i);
      for (int unsigned k = i; k + 1 < tbl_cnt; k++) begin
         tbl_m[k] = tbl_m[k+1];
         tbl_c[k] = tbl_c[k+1];
         tbl_bp[k] = tbl_bp[k+1];
      end
      tbl_cnt--;
   endfunction

   function automatic void place_line(logic signed [63:0] m, logic signed [63:0] c);
      int unsigned pos, y, x;
      bit dummy;
      pos = 0;
      while (pos < tbl_cnt && tbl_m[pos] <= m) pos++;
      for (int unsigned k = tbl_cnt; k > pos; k--) begin
         tbl_m[k] = tbl_m[k-1];
         tbl_c[k] = tbl_c[k-1];
         tbl_bp[k] = tbl_bp[k-1];
      end
      tbl_m[pos] = m;
      tbl_c[pos] = c;
      tbl_bp[pos] = 0;
      tbl_cnt++;
      y = pos;
      while (refresh_break(y, y + 1)) drop_line(y + 1);
      x = y;
      if (y != 0) begin
         x = y - 1;
         if (refresh_break(x, y)) begin
            drop_line(y);
            dummy = refresh_break(x, x + 1);
         end
      end
      while (x != 0 && tbl_bp[x-1] >= tbl_bp[x]) begin
         drop_line(x);
         x = x - 1;
         dummy = refresh_break(x, x + 1);
      end
   endfunction

   function automatic rsp_word_type predict_hull(req_word_type w);
      rsp_word_type r;
      logic signed [63:0] m, c, x;
      int unsigned i;
      r.value = 0;
      r.status = StOk;
      if (w.kind == ReqInsert) begin
         if (tbl_cnt >= Depth) r.status = StFull;
         else begin
            m = 64'($signed(w.slope));
            c = 64'($signed(w.icpt));
            if (model_min) begin
               m = -m;
               c = -c;
            end
            place_line(m, c);
         end
      end else if (tbl_cnt == 0) begin
         r.status = StEmpty;
      end else begin
         x = 64'($signed(w.x));
         i = 0;
         while (i + 1 < tbl_cnt && tbl_bp[i] < x) i++;
         r.value = tbl_m[i] * x + tbl_c[i];
         if (model_min) r.value = -r.value;
      end
      r.count = CntW'(tbl_cnt);
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_words.size() > 0 && (quiet_in || $urandom_range(99) >= 32)) begin
               req_word_type w;
               w = pending_words.pop_front();
               expected_rsp.push_back(predict_hull(w));
               req_type <= w.kind;
               req_line_slope <= w.slope;
               req_line_intercept <= w.icpt;
               req_query_x <= w.x;
               req_valid <= 1'b1;
            end else req_valid <= 1'b0;
         end
         rsp_ready <= quiet_out || ($urandom_range(99) >= 32);
      end
   end

   always @(posedge clock) req_ready_seen <= req_valid && req_ready;

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_word_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected word: value %0d count %0d status %0d", $time,
                     rsp_envelope_value, rsp_line_count, rsp_status);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_envelope_value !== e.value) begin
               $display("%0t: value expected %0d actual %0d", $time, e.value,
                        rsp_envelope_value);
               errors++;
            end
            if (rsp_line_count !== e.count) begin
               $display("%0t: count expected %0d actual %0d", $time, e.count,
                        rsp_line_count);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp_status);
               errors++;
            end
         end
      end
   end

   task automatic write_mode(logic mode);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrHullMode; pwdata <= {31'd0, mode};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      model_min = mode;
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return 32'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   task automatic add_word(logic kind, logic [31:0] s, logic [31:0] c, logic [31:0] x);
      req_word_type w;
      w.kind = kind; w.slope = s; w.icpt = c; w.x = x;
      pending_words.push_back(w);
   endtask

   initial begin
      tbl_cnt = 0;
      model_min = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty query, extremes, equal slopes, both modes
      add_word(ReqQuery, 0, 0, 32'h8000_0000);
      add_word(ReqInsert, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      add_word(ReqInsert, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      add_word(ReqInsert, 32'd5, 32'd10, 0);
      add_word(ReqInsert, 32'd5, 32'd3, 0);
      add_word(ReqInsert, 32'd5, 32'd10, 0);
      add_word(ReqQuery, 0, 0, 32'h7FFF_FFFF);
      add_word(ReqQuery, 0, 0, 32'h8000_0000);
      add_word(ReqQuery, 0, 0, 32'hFFFF_FFFF);
      add_word(ReqQuery, 0, 0, 32'd0);
      wait_drained();
      write_mode(1'b0);
      add_word(ReqInsert, 32'd0, 32'd0, 0);
      add_word(ReqInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      add_word(ReqQuery, 0, 0, 32'h7FFF_FFFF);
      add_word(ReqQuery, 0, 0, 32'h8000_0000);
      // fill to full: parabola-like lines all stay on the envelope
      for (int k = 0; k < 70; k++)
         add_word(ReqInsert, 32'(k * 2 - 60), 32'(-(k - 30) * (k - 30)), 0);
      add_word(ReqQuery, 0, 0, 32'd3);
      wait_drained();

      // random phases; mode mixed while lines are held
      for (int ph = 0; ph < 8; ph++) begin
         write_mode(ph[0]);
         quiet_in = (ph == 3);
         quiet_out = (ph == 3);
         for (int k = 0; k < 95; k++) begin
            if ($urandom_range(99) < 55)
               add_word(ReqInsert, pick_coef(), pick_coef(), $urandom);
            else
               add_word(ReqQuery, $urandom, $urandom,
                        $urandom_range(1) ? $urandom : 32'($signed($urandom_range(400)) - 200));
         end
         wait_drained();
      end

      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/dlh_pkg.sv
sv/dlh_ram.sv
sv/dlh_div.sv
sv/dlh_datapath.sv
sv/dlh_ctrl.sv
sv/dynamic_line_hull.sv
tb/sv/dynamic_line_hull_tb.sv
